// ===== rtl/core/ffsa_pkg.sv =====
package ffsa_pkg;

    localparam int HEAP_UNITS_DEF   = 2048;
    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int NAME_BITS_DEF    = 16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] name_key;
        logic [11:0] alloc_size;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] seg_start;
        logic [10:0] seg_end;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_WRITE,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DN,
        S_FINISH,
        S_OUT
    } state_t;

endpackage

// ===== rtl/core/ffsa_table.sv =====
// Segment table memory: one write port and one registered read port.
module ffsa_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 40
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    // Read returns the old data on a write to the same address; read data registered.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/first_fit_segment_allocator.sv =====
// First-fit segment allocator. Each request is handled by a sequencer that
// walks the segment table in memory through its single read port. A scan over
// the N entries in use finds the name and the first fit. An insert or a merge
// then moves the entries above the changed place one at a time, each read and
// then written to its new place. After reset, the S_INIT state writes the
// initial entry before the first request is taken. One response follows each
// request, and the input is not ready while a request is being worked on or
// its response waits.
module first_fit_segment_allocator #(
    parameter int HEAP_UNITS   = ffsa_pkg::HEAP_UNITS_DEF,
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int NAME_BITS    = ffsa_pkg::NAME_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ffsa_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ffsa_pkg::rsp_t m_data
);
    import ffsa_pkg::*;

    localparam int UW = $clog2(HEAP_UNITS);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW = 2 * UW + 1 + NAME_BITS;
    localparam int LW = (UW + 1 > 12) ? UW + 1 : 12;

    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [UW-1:0] U_ONE = UW'(1);

    typedef struct packed {
        logic [UW-1:0]        first;
        logic [UW-1:0]        last;
        logic                 is_free;
        logic [NAME_BITS-1:0] key;
    } seg_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        fit_reg, fit_next;
    logic [CW-1:0]        found_reg, found_next;
    logic [1:0]           rm_reg, rm_next;
    logic                 have_fit_reg, have_fit_next;
    logic                 have_name_reg, have_name_next;
    logic                 any_alloc_reg, any_alloc_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 cmd_reg;
    logic [NAME_BITS-1:0] key_reg;
    logic [11:0]          size_reg;
    seg_t                 hold_reg, hold_next;
    seg_t                 base_reg, base_next;
    rsp_t                 rsp_reg, rsp_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    seg_t          wdata, rdata;
    logic [DW-1:0] rraw;

    assign rdata = seg_t'(rraw);

    ffsa_table #(.DEPTH(MAX_SEGMENTS), .AW(AW), .DW(DW)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rraw)
    );

    // Size compare on the entry just read.
    logic [UW:0]   seg_len;
    logic          fits;
    assign seg_len = {1'b0, rdata.last} - {1'b0, rdata.first} + {{UW{1'b0}}, 1'b1};
    assign fits = (LW'(seg_len) >= LW'(size_reg));

    // Last unit of the allocated part and whether the fit must be split.
    logic [UW-1:0] alloc_last;
    logic          split;
    assign alloc_last = base_reg.first + UW'(size_reg) - U_ONE;
    assign split = (alloc_last != base_reg.last);

    // Entries still to be moved during an insert or a merge.
    logic shift_up_more, shift_dn_more;
    assign shift_up_more = split && (ptr_reg > fit_reg + C_ONE);
    assign shift_dn_more = (rm_reg != 2'd0) && (ptr_reg < count_reg);

    // Outcome of the scan, in the order the checks are made.
    status_t dec_status;
    always_comb begin
        dec_status = ST_OK;
        if (cmd_reg == CMD_ALLOC) begin
            if (have_name_reg) dec_status = ST_EXISTS;
            else if (size_reg == '0 || !have_fit_reg) dec_status = ST_NOFIT;
            else if (split && count_reg >= CW'(MAX_SEGMENTS)) dec_status = ST_FULL;
        end else begin
            if (!any_alloc_reg) dec_status = ST_EMPTY;
            else if (!have_name_reg) dec_status = ST_NOTFOUND;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = rsp_reg;

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            count_reg   <= C_ONE;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
        end
        idx_reg <= idx_next;
        ptr_reg <= ptr_next;
        fit_reg <= fit_next;
        found_reg <= found_next;
        rm_reg <= rm_next;
        have_fit_reg <= have_fit_next;
        have_name_reg <= have_name_next;
        any_alloc_reg <= any_alloc_next;
        hold_reg <= hold_next;
        base_reg <= base_next;
        rsp_reg  <= rsp_next;
        if (s_valid && s_ready) begin
            cmd_reg  <= s_data.cmd;
            key_reg  <= NAME_BITS'(s_data.name_key);
            size_reg <= s_data.alloc_size;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:      state_next = S_IDLE;
            S_IDLE:      if (s_valid) state_next = S_SCAN;
            S_SCAN:      if (rd_pend_reg && (idx_reg == count_reg)) state_next = S_DECIDE;
            S_DECIDE: begin
                if (dec_status != ST_OK) state_next = S_OUT;
                else if (cmd_reg == CMD_ALLOC) state_next = S_SHIFT_UP;
                else state_next = S_FREE_NEXT;
            end
            S_SHIFT_UP:  if (!rd_pend_reg && !shift_up_more) state_next = S_WRITE;
            S_WRITE:     state_next = S_FINISH;
            S_FREE_NEXT: if (rd_pend_reg) state_next = S_FREE_PREV;
            S_FREE_PREV: if (rd_pend_reg) state_next = S_SHIFT_DN;
            S_SHIFT_DN:  if (!rd_pend_reg && !shift_dn_more) state_next = S_FINISH;
            S_FINISH:    state_next = S_OUT;
            S_OUT:       if (m_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and table control.
    always_comb begin
        count_next = count_reg;
        idx_next = idx_reg;
        ptr_next = ptr_reg;
        fit_next = fit_reg;
        found_next = found_reg;
        rm_next = rm_reg;
        have_fit_next = have_fit_reg;
        have_name_next = have_name_reg;
        any_alloc_next = any_alloc_reg;
        rd_pend_next = 1'b0;
        hold_next = hold_reg;
        base_next = base_reg;
        rsp_next = rsp_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        case (state_reg)
            S_INIT: begin
                // Entry 0 holds the whole heap, free.
                we = 1'b1;
                wdata.last = UW'(HEAP_UNITS - 1);
                wdata.is_free = 1'b1;
                count_next = C_ONE;
            end
            S_IDLE: begin
                idx_next = '0;
                rm_next = '0;
                have_fit_next = 1'b0;
                have_name_next = 1'b0;
                any_alloc_next = 1'b0;
            end
            S_SCAN: begin
                // One entry per cycle: read issued, result examined next cycle.
                raddr = idx_reg[AW-1:0];
                if (rd_pend_reg) begin
                    if (!rdata.is_free) begin
                        any_alloc_next = 1'b1;
                        if (rdata.key == key_reg && !have_name_reg) begin
                            have_name_next = 1'b1;
                            found_next = idx_reg - C_ONE;
                            hold_next = rdata;
                        end
                    end else if (fits && !have_fit_reg) begin
                        have_fit_next = 1'b1;
                        fit_next = idx_reg - C_ONE;
                        base_next = rdata;
                    end
                end
                if (idx_reg != count_reg) begin
                    rd_pend_next = 1'b1;
                    idx_next = idx_reg + C_ONE;
                end
            end
            S_DECIDE: begin
                rsp_next = '0;
                rsp_next.status = dec_status;
                if (dec_status == ST_OK) begin
                    if (cmd_reg == CMD_ALLOC) begin
                        rsp_next.seg_start = 11'(base_reg.first);
                        rsp_next.seg_end = 11'(alloc_last);
                        ptr_next = count_reg;
                    end else begin
                        base_next = hold_reg;
                        base_next.is_free = 1'b1;
                        base_next.key = '0;
                        idx_next = found_reg;
                        rm_next = '0;
                    end
                end
            end
            S_SHIFT_UP: begin
                // Move entries up by one from the top down to fit+1.
                if (shift_up_more) begin
                    if (rd_pend_reg) begin
                        we = 1'b1;
                        waddr = ptr_reg[AW-1:0];
                        wdata = rdata;
                        ptr_next = ptr_reg - C_ONE;
                    end else begin
                        raddr = AW'(ptr_reg - C_ONE);
                        rd_pend_next = 1'b1;
                    end
                end
            end
            S_WRITE: begin
                // The allocated front part takes the place of the fit.
                we = 1'b1;
                waddr = fit_reg[AW-1:0];
                wdata.first = base_reg.first;
                wdata.last = alloc_last;
                wdata.is_free = 1'b0;
                wdata.key = key_reg;
            end
            S_FREE_NEXT: begin
                // Look at the right neighbour.
                if (rd_pend_reg) begin
                    if (found_reg + C_ONE < count_reg && rdata.is_free) begin
                        base_next.last = rdata.last;
                        rm_next = 2'd1;
                    end
                end else begin
                    raddr = AW'(found_reg + C_ONE);
                    rd_pend_next = 1'b1;
                end
            end
            S_FREE_PREV: begin
                // Look at the left neighbour; rm counts entries to remove.
                if (rd_pend_reg) begin
                    ptr_next = found_reg + C_ONE + CW'(rm_reg);
                    if (found_reg != '0 && rdata.is_free) begin
                        base_next.first = rdata.first;
                        rm_next = rm_reg + 2'd1;
                        idx_next = found_reg - C_ONE;
                    end
                end else begin
                    raddr = AW'(found_reg - C_ONE);
                    rd_pend_next = 1'b1;
                end
            end
            S_SHIFT_DN: begin
                // Close the gap left by the merged entries, from ptr upwards.
                if (shift_dn_more) begin
                    if (rd_pend_reg) begin
                        we = 1'b1;
                        waddr = AW'(ptr_reg - CW'(rm_reg));
                        wdata = rdata;
                        ptr_next = ptr_reg + C_ONE;
                    end else begin
                        raddr = ptr_reg[AW-1:0];
                        rd_pend_next = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (cmd_reg == CMD_ALLOC) begin
                    // The remainder of a split fit stays free behind it.
                    we = split;
                    waddr = AW'(fit_reg + C_ONE);
                    wdata.first = alloc_last + U_ONE;
                    wdata.last = base_reg.last;
                    wdata.is_free = 1'b1;
                    wdata.key = '0;
                    if (split) count_next = count_reg + C_ONE;
                end else begin
                    we = 1'b1;
                    waddr = idx_reg[AW-1:0];
                    wdata = base_reg;
                    count_next = count_reg - CW'(rm_reg);
                    rsp_next.seg_start = 11'(base_reg.first);
                    rsp_next.seg_end = 11'(base_reg.last);
                end
            end
            default: begin
            end
        endcase
    end
endmodule
